>>> rtl/sdcs_pkg.sv
package sdcs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FWD   = 3'd1,
    PH_PAUSE = 3'd2,
    PH_BACK  = 3'd3,
    PH_VIB   = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic [2:0] REG_START_ANGLE      = 3'd0;
  localparam logic [2:0] REG_TARGET_ANGLE     = 3'd1;
  localparam logic [2:0] REG_STEP_ANGLE       = 3'd2;
  localparam logic [2:0] REG_STEP_INTERVAL_MS = 3'd3;
  localparam logic [2:0] REG_PAUSE_MS         = 3'd4;
  localparam logic [2:0] REG_VIBRATE_MS       = 3'd5;
  localparam logic [2:0] REG_VIBRATOR_PRESENT = 3'd6;

  localparam logic [7:0]  RST_START_ANGLE      = 8'd180;
  localparam logic [7:0]  RST_TARGET_ANGLE     = 8'd20;
  localparam logic [7:0]  RST_STEP_ANGLE       = 8'd5;
  localparam logic [15:0] RST_STEP_INTERVAL_MS = 16'd15;
  localparam logic [15:0] RST_PAUSE_MS         = 16'd500;
  localparam logic [15:0] RST_VIBRATE_MS       = 16'd150;
  localparam logic        RST_VIBRATOR_PRESENT = 1'b1;

  typedef struct packed {
    logic [7:0]  start_angle;
    logic [7:0]  target_angle;
    logic [7:0]  step_angle;
    logic [15:0] step_interval_ms;
    logic [15:0] pause_ms;
    logic [15:0] vibrate_ms;
    logic        vibrator_present;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] remaining;
    logic [15:0] elapsed_ms;
    logic [7:0]  position;
    logic        vibrator_level;
  } seq_state_t;

endpackage

>>> rtl/sdcs_step.sv
module sdcs_step (
  input  sdcs_pkg::seq_state_t cur,
  input  sdcs_pkg::cfg_t       cfg,
  input  logic [1:0]           kind,
  input  logic [15:0]          cycle_count,
  output sdcs_pkg::seq_state_t nxt,
  output logic                 wrote
);
  import sdcs_pkg::*;

  logic [15:0] elapsed_inc;
  logic [7:0]  fwd_dist;
  logic [7:0]  back_dist;
  logic [7:0]  fwd_pos;
  logic [7:0]  back_pos;
  logic        fwd_move;
  logic        back_move;
  logic [15:0] rem_dec;
  logic        step_due;
  logic        pause_due;
  logic        vib_due;

  // saturating millisecond count
  assign elapsed_inc = (cur.elapsed_ms == 16'hFFFF) ? cur.elapsed_ms
                                                    : cur.elapsed_ms + 16'd1;
  assign step_due  = elapsed_inc >= cfg.step_interval_ms;
  assign pause_due = elapsed_inc >= cfg.pause_ms;
  assign vib_due   = elapsed_inc >= cfg.vibrate_ms;

  assign fwd_move  = cur.position > cfg.target_angle;
  assign fwd_dist  = cur.position - cfg.target_angle;
  assign fwd_pos   = !fwd_move ? cur.position :
                     (cfg.step_angle >= fwd_dist) ? cfg.target_angle
                                                  : cur.position - cfg.step_angle;

  assign back_move = cur.position < cfg.start_angle;
  assign back_dist = cfg.start_angle - cur.position;
  assign back_pos  = !back_move ? cur.position :
                     (cfg.step_angle >= back_dist) ? cfg.start_angle
                                                   : cur.position + cfg.step_angle;

  assign rem_dec = (cur.remaining != 16'd0) ? cur.remaining - 16'd1 : 16'd0;

  always_comb begin
    nxt   = cur;
    wrote = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        if (cur.phase != PH_IDLE) begin
          nxt.elapsed_ms = elapsed_inc;
        end
        unique case (cur.phase)
          PH_IDLE: begin
          end
          PH_FWD: begin
            if (step_due) begin
              nxt.elapsed_ms = 16'd0;
              nxt.position   = fwd_pos;
              wrote          = fwd_move;
              if (fwd_pos <= cfg.target_angle) begin
                nxt.phase = PH_PAUSE;
              end
            end
          end
          PH_PAUSE: begin
            if (pause_due) begin
              nxt.elapsed_ms = 16'd0;
              nxt.phase      = PH_BACK;
            end
          end
          PH_BACK: begin
            if (step_due) begin
              nxt.elapsed_ms = 16'd0;
              nxt.position   = back_pos;
              wrote          = back_move;
              if (back_pos >= cfg.start_angle) begin
                nxt.phase = PH_VIB;
                if (cfg.vibrator_present) begin
                  nxt.vibrator_level = 1'b1;
                end
              end
            end
          end
          PH_VIB: begin
            if (vib_due) begin
              nxt.vibrator_level = 1'b0;
              nxt.remaining      = rem_dec;
              if (rem_dec != 16'd0) begin
                nxt.position   = cfg.start_angle;
                nxt.elapsed_ms = 16'd0;
                nxt.phase      = PH_FWD;
              end else begin
                nxt.phase = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      KIND_START: begin
        if (cycle_count != 16'd0) begin
          nxt.remaining  = cycle_count;
          nxt.position   = cfg.start_angle;
          nxt.elapsed_ms = 16'd0;
          nxt.phase      = PH_FWD;
          wrote          = 1'b1;
        end
      end
      KIND_STOP: begin
        nxt.remaining      = 16'd0;
        nxt.phase          = PH_IDLE;
        nxt.vibrator_level = 1'b0;
        nxt.position       = cfg.start_angle;
        wrote              = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/servo_dispense_cycle_sequencer_core.sv
// Servo dispense sequencer. Each input beat (a millisecond tick, a start with
// a cycle count, or a stop) yields exactly one output beat carrying the servo
// angle, whether a new angle was commanded, the vibrator level, the busy flag
// and the cycles still to run. A beat is registered on entry and resolved
// by one pass of compare-and-add logic into the output register, so the block
// sustains one beat per clock while the output is not stalled; backpressure
// on the output stalls the input only when both stages are full. Registers
// are written through the cfg port; the user must write them only while no
// beat is in flight (not enforced here); they take effect on the next beat.
module servo_dispense_cycle_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] cycle_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  servo_angle,
  output logic        angle_written,
  output logic        vibrator_on,
  output logic        busy_res,
  output logic [15:0] cycles_left
);
  import sdcs_pkg::*;

  cfg_t        cfg;
  seq_state_t  state;
  seq_state_t  state_next;
  logic        wrote;
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [15:0] s1_count;
  logic        s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle      <= RST_START_ANGLE;
      cfg.target_angle     <= RST_TARGET_ANGLE;
      cfg.step_angle       <= RST_STEP_ANGLE;
      cfg.step_interval_ms <= RST_STEP_INTERVAL_MS;
      cfg.pause_ms         <= RST_PAUSE_MS;
      cfg.vibrate_ms       <= RST_VIBRATE_MS;
      cfg.vibrator_present <= RST_VIBRATOR_PRESENT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_ANGLE:      cfg.start_angle      <= cfg_data[7:0];
        REG_TARGET_ANGLE:     cfg.target_angle     <= cfg_data[7:0];
        REG_STEP_ANGLE:       cfg.step_angle       <= cfg_data[7:0];
        REG_STEP_INTERVAL_MS: cfg.step_interval_ms <= cfg_data;
        REG_PAUSE_MS:         cfg.pause_ms         <= cfg_data;
        REG_VIBRATE_MS:       cfg.vibrate_ms       <= cfg_data;
        REG_VIBRATOR_PRESENT: cfg.vibrator_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // resolve the held beat whenever the output register is free or draining
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind  <= kind;
      s1_count <= cycle_count;
    end
  end

  sdcs_step u_step (
    .cur         (state),
    .cfg         (cfg),
    .kind        (s1_kind),
    .cycle_count (s1_count),
    .nxt         (state_next),
    .wrote       (wrote)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_IDLE;
      state.remaining      <= 16'd0;
      state.elapsed_ms     <= 16'd0;
      state.position       <= RST_START_ANGLE;
      state.vibrator_level <= 1'b0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      servo_angle   <= state_next.position;
      angle_written <= wrote;
      vibrator_on   <= state_next.vibrator_level;
      busy_res      <= (state_next.phase != PH_IDLE);
      cycles_left   <= state_next.remaining;
    end
  end

endmodule
